/* hdl/pqc_pkg.sv */
// pqc_pkg: shared constants for the projected quad cull block
// status codes, register indexes, widths and reset values, corner and area tables
// no dependencies
`timescale 1ns / 1ps

package pqc_pkg;

   // corners of one face
   localparam int NUM_CORNERS      = 4;
   localparam int CORNER_IDX_BITS  = 2;

   // doubled areas: 012, 023, 123, 230, 301
   localparam int NUM_AREAS = 5;
   localparam logic [CORNER_IDX_BITS-1:0] AREA_A [NUM_AREAS] = '{2'd0, 2'd0, 2'd1, 2'd2, 2'd3};
   localparam logic [CORNER_IDX_BITS-1:0] AREA_B [NUM_AREAS] = '{2'd1, 2'd2, 2'd2, 2'd3, 2'd0};
   localparam logic [CORNER_IDX_BITS-1:0] AREA_C [NUM_AREAS] = '{2'd2, 2'd3, 2'd3, 2'd0, 2'd1};
   localparam int AREA_012 = 0;
   localparam int AREA_023 = 1;
   localparam int AREA_123 = 2;
   localparam int AREA_230 = 3;
   localparam int AREA_301 = 4;

   // result status codes
   localparam logic [1:0] STATUS_VISIBLE  = 2'd0;
   localparam logic [1:0] STATUS_OFF_X    = 2'd1;
   localparam logic [1:0] STATUS_UNSTABLE = 2'd2;
   localparam logic [1:0] STATUS_OFF_Y    = 2'd3;

   // register port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int SCREEN_BITS    = 15;
   localparam int AREA_THR_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_TWICE_AREA = 2'd2;

   // register reset values
   localparam logic [SCREEN_BITS-1:0]   SCREEN_WIDTH_RST   = 15'd240;
   localparam logic [SCREEN_BITS-1:0]   SCREEN_HEIGHT_RST  = 15'd160;
   localparam logic [AREA_THR_BITS-1:0] MIN_TWICE_AREA_RST = 16'd24;

endpackage

/* hdl/pqc_bbox.sv */
// pqc_bbox: bounding box and top corner search over four corners
// combinational; uses pqc_pkg for corner count and index width
`timescale 1ns / 1ps

module pqc_bbox #(
   parameter int COORD_BITS = 16
) (
   input  logic [pqc_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] xs,
   input  logic [pqc_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] ys,
   output logic [COORD_BITS-1:0]                           min_x,
   output logic [COORD_BITS-1:0]                           max_x,
   output logic [COORD_BITS-1:0]                           min_y,
   output logic [COORD_BITS-1:0]                           max_y,
   output logic [pqc_pkg::CORNER_IDX_BITS-1:0]             top_corner
);
   import pqc_pkg::*;

   // running min and max, first strictly smaller y takes the top corner
   always_comb begin
      min_x      = xs[0];
      max_x      = xs[0];
      min_y      = ys[0];
      max_y      = ys[0];
      top_corner = '0;
      for (int i = 1; i < NUM_CORNERS; i++) begin
         if ($signed(xs[i]) < $signed(min_x)) begin
            min_x = xs[i];
         end
         if ($signed(xs[i]) > $signed(max_x)) begin
            max_x = xs[i];
         end
         if ($signed(ys[i]) < $signed(min_y)) begin
            min_y      = ys[i];
            top_corner = CORNER_IDX_BITS'(i);
         end
         if ($signed(ys[i]) > $signed(max_y)) begin
            max_y = ys[i];
         end
      end
   end

endmodule

/* hdl/projected_quad_cull.sv */
// projected_quad_cull: visibility and stability cull for one projected face
// path from input word accept to rsp_tvalid: input, product and result registers
// throughput: one face per cycle; the product register after the ten area multipliers
// sets the stage boundary, and each stage advances when the one after it has room
// reset: synchronous, clears all stage valids and loads the screen and area defaults
// depends on pqc_pkg and pqc_bbox
`timescale 1ns / 1ps

module projected_quad_cull #(
   parameter int COORD_BITS = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   // input words
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // x0, y0, x1, y1, x2, y2, x3, y3 from the lowest bit up
   input  logic [8*COORD_BITS-1:0]                      req_tdata,
   // is_triangle
   input  logic                                         req_tuser,
   // result words
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // status, top_corner, min_x, max_x, min_y, max_y from the lowest bit up, zero padded
   output logic [((4*COORD_BITS+4+7)/8)*8-1:0]          rsp_tdata,
   // register writes
   input  logic                                         csr_wen,
   input  logic [pqc_pkg::CSR_INDEX_BITS-1:0]           csr_index,
   input  logic [pqc_pkg::CSR_DATA_BITS-1:0]            csr_wdata
);
   import pqc_pkg::*;

   localparam int CB       = COORD_BITS;
   localparam int DW       = CB + 1;                 // corner difference
   localparam int PW       = 2 * DW;                 // product
   localparam int AW       = PW + 1;                 // doubled area
   localparam int CW       = ((CB > 16) ? CB : 16) + 1; // screen compare
   localparam int RSP_BITS = ((4 * CB + 4 + 7) / 8) * 8;

   // configuration registers
   logic [SCREEN_BITS-1:0]   screen_width_ff,   screen_width_in;
   logic [SCREEN_BITS-1:0]   screen_height_ff,  screen_height_in;
   logic [AREA_THR_BITS-1:0] min_twice_area_ff, min_twice_area_in;

   always_comb begin
      screen_width_in   = screen_width_ff;
      screen_height_in  = screen_height_ff;
      min_twice_area_in = min_twice_area_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:   screen_width_in   = csr_wdata[SCREEN_BITS-1:0];
            CSR_SCREEN_HEIGHT:  screen_height_in  = csr_wdata[SCREEN_BITS-1:0];
            CSR_MIN_TWICE_AREA: min_twice_area_in = csr_wdata[AREA_THR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff   <= SCREEN_WIDTH_RST;
         screen_height_ff  <= SCREEN_HEIGHT_RST;
         min_twice_area_ff <= MIN_TWICE_AREA_RST;
      end else begin
         screen_width_ff   <= screen_width_in;
         screen_height_ff  <= screen_height_in;
         min_twice_area_ff <= min_twice_area_in;
      end
   end

   // stage handshakes: a stage loads when it is empty or its word moves on
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic s1_ready, s2_ready, s3_ready;

   assign s3_ready   = !rsp_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   // input register
   logic [NUM_CORNERS-1:0][CB-1:0] s1_x_ff, s1_y_ff;
   logic                           s1_tri_ff;

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         for (int i = 0; i < NUM_CORNERS; i++) begin
            s1_x_ff[i] <= req_tdata[2*i*CB +: CB];
            s1_y_ff[i] <= req_tdata[(2*i+1)*CB +: CB];
         end
         s1_tri_ff <= req_tuser;
      end
   end

   // bounding box and top corner
   logic [CB-1:0]              bb_min_x, bb_max_x, bb_min_y, bb_max_y;
   logic [CORNER_IDX_BITS-1:0] bb_top;

   pqc_bbox #(
      .COORD_BITS (CB)
   ) u_bbox (
      .xs         (s1_x_ff),
      .ys         (s1_y_ff),
      .min_x      (bb_min_x),
      .max_x      (bb_max_x),
      .min_y      (bb_min_y),
      .max_y      (bb_max_y),
      .top_corner (bb_top)
   );

   // area cross products: (xb-xa)*(yc-ya) and (yb-ya)*(xc-xa)
   logic signed [DW-1:0] d_xb [NUM_AREAS];
   logic signed [DW-1:0] d_yc [NUM_AREAS];
   logic signed [DW-1:0] d_yb [NUM_AREAS];
   logic signed [DW-1:0] d_xc [NUM_AREAS];
   logic signed [PW-1:0] prod_a [NUM_AREAS];
   logic signed [PW-1:0] prod_b [NUM_AREAS];

   always_comb begin
      for (int k = 0; k < NUM_AREAS; k++) begin
         d_xb[k] = $signed({s1_x_ff[AREA_B[k]][CB-1], s1_x_ff[AREA_B[k]]})
                 - $signed({s1_x_ff[AREA_A[k]][CB-1], s1_x_ff[AREA_A[k]]});
         d_yc[k] = $signed({s1_y_ff[AREA_C[k]][CB-1], s1_y_ff[AREA_C[k]]})
                 - $signed({s1_y_ff[AREA_A[k]][CB-1], s1_y_ff[AREA_A[k]]});
         d_yb[k] = $signed({s1_y_ff[AREA_B[k]][CB-1], s1_y_ff[AREA_B[k]]})
                 - $signed({s1_y_ff[AREA_A[k]][CB-1], s1_y_ff[AREA_A[k]]});
         d_xc[k] = $signed({s1_x_ff[AREA_C[k]][CB-1], s1_x_ff[AREA_C[k]]})
                 - $signed({s1_x_ff[AREA_A[k]][CB-1], s1_x_ff[AREA_A[k]]});
         prod_a[k] = d_xb[k] * d_yc[k];
         prod_b[k] = d_yb[k] * d_xc[k];
      end
   end

   // product register
   logic signed [PW-1:0]       s2_pa_ff [NUM_AREAS];
   logic signed [PW-1:0]       s2_pb_ff [NUM_AREAS];
   logic [CB-1:0]              s2_min_x_ff, s2_max_x_ff, s2_min_y_ff, s2_max_y_ff;
   logic [CORNER_IDX_BITS-1:0] s2_top_ff;
   logic                       s2_tri_ff;

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         for (int k = 0; k < NUM_AREAS; k++) begin
            s2_pa_ff[k] <= prod_a[k];
            s2_pb_ff[k] <= prod_b[k];
         end
         s2_min_x_ff <= bb_min_x;
         s2_max_x_ff <= bb_max_x;
         s2_min_y_ff <= bb_min_y;
         s2_max_y_ff <= bb_max_y;
         s2_top_ff   <= bb_top;
         s2_tri_ff   <= s1_tri_ff;
      end
   end

   // doubled areas, magnitude against threshold, strict signs
   logic signed [AW-1:0] area [NUM_AREAS];
   logic [AW-1:0]        area_mag [NUM_AREAS];
   logic [AW-1:0]        thr_ext;
   logic [NUM_AREAS-1:0] area_ge, area_pos, area_neg;

   assign thr_ext = {{(AW-AREA_THR_BITS){1'b0}}, min_twice_area_ff};

   always_comb begin
      for (int k = 0; k < NUM_AREAS; k++) begin
         area[k]     = $signed({s2_pa_ff[k][PW-1], s2_pa_ff[k]})
                     - $signed({s2_pb_ff[k][PW-1], s2_pb_ff[k]});
         area_mag[k] = area[k][AW-1] ? AW'(-area[k]) : AW'(area[k]);
         area_ge[k]  = area_mag[k] >= thr_ext;
         area_neg[k] = area[k][AW-1];
         area_pos[k] = !area[k][AW-1] && (area[k] != '0);
      end
   end

   logic ss_012_023, ss_012_123, ss_123_230, ss_230_301;
   logic stable;

   assign ss_012_023 = (area_pos[AREA_012] && area_pos[AREA_023])
                    || (area_neg[AREA_012] && area_neg[AREA_023]);
   assign ss_012_123 = (area_pos[AREA_012] && area_pos[AREA_123])
                    || (area_neg[AREA_012] && area_neg[AREA_123]);
   assign ss_123_230 = (area_pos[AREA_123] && area_pos[AREA_230])
                    || (area_neg[AREA_123] && area_neg[AREA_230]);
   assign ss_230_301 = (area_pos[AREA_230] && area_pos[AREA_301])
                    || (area_neg[AREA_230] && area_neg[AREA_301]);

   assign stable = s2_tri_ff ? area_ge[AREA_012]
                 : (area_ge[AREA_012] && area_ge[AREA_023] && ss_012_023
                    && ss_012_123 && ss_123_230 && ss_230_301);

   // screen range tests on the bounding box
   logic signed [CW-1:0] min_x_ext, max_x_ext, min_y_ext, max_y_ext;
   logic signed [CW-1:0] width_ext, height_ext;
   logic                 on_x, on_y;

   assign min_x_ext  = $signed({{(CW-CB){s2_min_x_ff[CB-1]}}, s2_min_x_ff});
   assign max_x_ext  = $signed({{(CW-CB){s2_max_x_ff[CB-1]}}, s2_max_x_ff});
   assign min_y_ext  = $signed({{(CW-CB){s2_min_y_ff[CB-1]}}, s2_min_y_ff});
   assign max_y_ext  = $signed({{(CW-CB){s2_max_y_ff[CB-1]}}, s2_max_y_ff});
   assign width_ext  = $signed({{(CW-SCREEN_BITS){1'b0}}, screen_width_ff});
   assign height_ext = $signed({{(CW-SCREEN_BITS){1'b0}}, screen_height_ff});
   assign on_x = (min_x_ext < width_ext) && !max_x_ext[CW-1];
   assign on_y = (min_y_ext < height_ext) && !max_y_ext[CW-1];

   // x test first, then stability, then y
   logic [1:0] status_in;

   always_comb begin
      if (!on_x) begin
         status_in = STATUS_OFF_X;
      end else if (!stable) begin
         status_in = STATUS_UNSTABLE;
      end else if (!on_y) begin
         status_in = STATUS_OFF_Y;
      end else begin
         status_in = STATUS_VISIBLE;
      end
   end

   // result register
   logic [1:0]                 status_ff;
   logic [CORNER_IDX_BITS-1:0] top_ff;
   logic [CB-1:0]              min_x_ff, max_x_ff, min_y_ff, max_y_ff;

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         status_ff <= status_in;
         top_ff    <= s2_top_ff;
         min_x_ff  <= s2_min_x_ff;
         max_x_ff  <= s2_max_x_ff;
         min_y_ff  <= s2_min_y_ff;
         max_y_ff  <= s2_max_y_ff;
      end
   end

   assign rsp_tdata = RSP_BITS'({max_y_ff, min_y_ff, max_x_ff, min_x_ff, top_ff, status_ff});

endmodule

/* tb/tb.sv */
// tb: self-checking bench for the projected quad cull block
// a table of directed faces, then random faces over several screen and area settings
// depends on pqc_pkg and projected_quad_cull
`timescale 1ns / 1ps

module tb;
   import pqc_pkg::*;

   localparam int CB          = 16;
   localparam int RSP_W       = ((4*CB+4+7)/8)*8;
   localparam int LATENCY     = 3;
   localparam int HOLD_CYCLES = 400;
   localparam int C_MAX       = 2**(CB-1) - 1;
   localparam int C_MIN       = -(2**(CB-1));
   localparam longint TIMEOUT_NS = 10_000_000;

   // random phases: screen size, area threshold and face count
   localparam int NUM_PHASES = 8;
   localparam int PH_W     [NUM_PHASES] = '{240, 1, 32767, 320, 64, 32767, 1, 240};
   localparam int PH_H     [NUM_PHASES] = '{160, 1, 32767, 240, 48, 1, 32767, 160};
   localparam int PH_THR   [NUM_PHASES] = '{24, 0, 65535, 1, 200, 0, 65535, 24};
   localparam int PH_ITEMS [NUM_PHASES] = '{300, 150, 200, 250, 250, 150, 150, 350};
   localparam int HOLD_PHASE = 3;

   typedef logic signed [CB-1:0] coord_type;

   typedef struct packed {
      coord_type [NUM_CORNERS-1:0] x;
      coord_type [NUM_CORNERS-1:0] y;
      logic                        is_tri;
   } face_type;

   typedef struct packed {
      logic [1:0] status;
      logic [1:0] top_corner;
      coord_type  min_x;
      coord_type  max_x;
      coord_type  min_y;
      coord_type  max_y;
   } cull_result_type;

   typedef struct packed {
      face_type                 face;
      logic [AREA_THR_BITS-1:0] thr;
      logic                     known;
      cull_result_type          want;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // x0, y0, x1, y1, x2, y2, x3, y3 from the lowest bit up
   logic [8*CB-1:0] req_tdata = '0;
   // is_triangle
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // status, top_corner, min_x, max_x, min_y, max_y from the lowest bit up, zero padded
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_wen = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // bench copy of the registers
   logic [SCREEN_BITS-1:0]   cur_width  = SCREEN_WIDTH_RST;
   logic [SCREEN_BITS-1:0]   cur_height = SCREEN_HEIGHT_RST;
   logic [AREA_THR_BITS-1:0] cur_thr    = MIN_TWICE_AREA_RST;

   bit snd_idling = 1'b1;
   bit rsp_idling = 1'b1;
   int hold_requests = 0;
   int fail_count = 0;

   cull_result_type expected_culls[$];
   stim_row_type    dir_rows[$];

   projected_quad_cull #(.COORD_BITS(CB)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // give up after a generous fixed time
   initial begin
      #(TIMEOUT_NS);
      $display("tb: FAIL");
      $finish;
   end

   // doubled signed area of corners a, b, c, exact
   function automatic longint twice_area(input face_type f, input int a, input int b,
                                         input int c);
      longint ax, ay, bx, by, cx, cy;
      ax = f.x[a]; ay = f.y[a];
      bx = f.x[b]; by = f.y[b];
      cx = f.x[c]; cy = f.y[c];
      return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
   endfunction

   function automatic longint mag(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // strictly the same sign, a zero never agrees
   function automatic bit agree(input longint a, input longint b);
      return (a > 0 && b > 0) || (a < 0 && b < 0);
   endfunction

   // bounding box, top corner and cull status of one face
   function automatic cull_result_type predict_cull(input face_type f);
      longint area [NUM_AREAS];
      longint thr;
      int mnx, mxx, mny, mxy;
      bit stable;
      cull_result_type r;
      mnx = f.x[0]; mxx = f.x[0];
      mny = f.y[0]; mxy = f.y[0];
      r.top_corner = 2'd0;
      for (int i = 1; i < NUM_CORNERS; i++) begin
         if (f.x[i] < mnx) mnx = f.x[i];
         if (f.x[i] > mxx) mxx = f.x[i];
         if (f.y[i] < mny) begin
            mny = f.y[i];
            r.top_corner = 2'(i);
         end
         if (f.y[i] > mxy) mxy = f.y[i];
      end
      for (int k = 0; k < NUM_AREAS; k++)
         area[k] = twice_area(f, AREA_A[k], AREA_B[k], AREA_C[k]);
      thr = cur_thr;
      if (f.is_tri) begin
         stable = mag(area[AREA_012]) >= thr;
      end else begin
         stable = mag(area[AREA_012]) >= thr && mag(area[AREA_023]) >= thr &&
                  agree(area[AREA_012], area[AREA_023]) &&
                  agree(area[AREA_012], area[AREA_123]) &&
                  agree(area[AREA_123], area[AREA_230]) &&
                  agree(area[AREA_230], area[AREA_301]);
      end
      // x test first, then stability, then y
      if (!(mnx < int'(cur_width) && mxx >= 0))
         r.status = STATUS_OFF_X;
      else if (!stable)
         r.status = STATUS_UNSTABLE;
      else if (!(mny < int'(cur_height) && mxy >= 0))
         r.status = STATUS_OFF_Y;
      else
         r.status = STATUS_VISIBLE;
      r.min_x = coord_type'(mnx);
      r.max_x = coord_type'(mxx);
      r.min_y = coord_type'(mny);
      r.max_y = coord_type'(mxy);
      return r;
   endfunction

   function automatic coord_type clip(input int v);
      if (v > C_MAX) return coord_type'(C_MAX);
      if (v < C_MIN) return coord_type'(C_MIN);
      return coord_type'(v);
   endfunction

   // jittered rectangle around a centre, convex for jitter under a quarter of the size
   function automatic face_type make_face(input int cx, input int cy, input int hw,
                                          input int hh, input bit is_tri, input bit flat);
      int px [4];
      int py [4];
      int jm, t, r, j;
      bit flip;
      face_type f;
      jm = ((hw < hh) ? hw : hh) / 4;
      px[0] = cx - hw; py[0] = cy - hh;
      px[1] = cx + hw; py[1] = cy - hh;
      px[2] = cx + hw; py[2] = cy + hh;
      px[3] = cx - hw; py[3] = cy + hh;
      for (int i = 0; i < 4; i++) begin
         t = $urandom_range(0, 2*jm);
         px[i] += t - jm;
         t = $urandom_range(0, 2*jm);
         py[i] += t - jm;
      end
      // degenerate shapes: repeated corner, flat row, corner on a line
      if (flat) begin
         case ($urandom_range(0, 2))
            0: begin
               px[2] = px[1];
               py[2] = py[1];
            end
            1: for (int i = 0; i < 4; i++) py[i] = cy;
            default: begin
               px[2] = 2*px[1] - px[0];
               py[2] = 2*py[1] - py[0];
            end
         endcase
      end
      // random starting corner and winding
      r = $urandom_range(0, 3);
      flip = 1'($urandom_range(0, 1));
      for (int i = 0; i < 4; i++) begin
         j = flip ? ((r - i) & 3) : ((r + i) & 3);
         f.x[i] = clip(px[j]);
         f.y[i] = clip(py[j]);
      end
      // a triangle's spare corner still widens the box
      if (is_tri && $urandom_range(0, 1)) begin
         t = $urandom_range(0, 4*hw);
         f.x[3] = clip(cx + t - 2*hw);
         t = $urandom_range(0, 4*hh);
         f.y[3] = clip(cy + t - 2*hh);
      end
      f.is_tri = is_tri;
      return f;
   endfunction

   function automatic face_type random_face();
      int k, w, h, hw, hh, cx, cy, sel;
      bit is_tri;
      face_type f;
      w = int'(cur_width);
      h = int'(cur_height);
      k = $urandom_range(0, 99);
      is_tri = 1'($urandom_range(0, 1));
      hw = $urandom_range(2, 40);
      hh = $urandom_range(2, 40);
      if ($urandom_range(0, 7) == 0) begin
         hw = $urandom_range(40, 3000);
         hh = $urandom_range(40, 3000);
      end
      cx = $urandom_range(0, w - 1);
      cy = $urandom_range(0, h - 1);
      // raw coordinates, leaning on the extremes
      if (k < 10) begin
         for (int i = 0; i < NUM_CORNERS; i++) begin
            for (int a = 0; a < 2; a++) begin
               sel = $urandom_range(0, 7);
               case (sel)
                  0: f.x[i] = coord_type'(C_MIN);
                  1: f.x[i] = coord_type'(C_MAX);
                  2: f.x[i] = '0;
                  3: f.x[i] = '1;
                  default: f.x[i] = coord_type'($urandom);
               endcase
               if (a == 0) f.y[i] = f.x[i];
            end
         end
         f.is_tri = is_tri;
         return f;
      end
      if (k < 45) return make_face(cx, cy, hw, hh, 1'b0, 1'b0);
      if (k < 65) return make_face(cx, cy, hw, hh, 1'b1, 1'b0);
      // near the area threshold
      if (k < 75)
         return make_face(cx, cy, $urandom_range(1, 4), $urandom_range(1, 4), is_tri, 1'b0);
      // around and beyond the screen edges
      if (k < 90) begin
         cx = int'($urandom_range(0, 3*w)) - w;
         cy = int'($urandom_range(0, 3*h)) - h;
         return make_face(cx, cy, hw, hh, is_tri, 1'b0);
      end
      return make_face(cx, cy, hw, hh, is_tri, 1'b1);
   endfunction

   task automatic add_row(input int x0, input int y0, input int x1, input int y1,
                          input int x2, input int y2, input int x3, input int y3,
                          input bit is_tri, input int thr, input bit known = 1'b0,
                          input logic [1:0] st = STATUS_VISIBLE, input int top = 0,
                          input int mnx = 0, input int mxx = 0,
                          input int mny = 0, input int mxy = 0);
      stim_row_type r;
      r.face.x[0] = coord_type'(x0); r.face.y[0] = coord_type'(y0);
      r.face.x[1] = coord_type'(x1); r.face.y[1] = coord_type'(y1);
      r.face.x[2] = coord_type'(x2); r.face.y[2] = coord_type'(y2);
      r.face.x[3] = coord_type'(x3); r.face.y[3] = coord_type'(y3);
      r.face.is_tri = is_tri;
      r.thr = AREA_THR_BITS'(thr);
      r.known = known;
      r.want.status = st;
      r.want.top_corner = 2'(top);
      r.want.min_x = coord_type'(mnx);
      r.want.max_x = coord_type'(mxx);
      r.want.min_y = coord_type'(mny);
      r.want.max_y = coord_type'(mxy);
      dir_rows.push_back(r);
   endtask

   // offer one face, wait for it to be taken, queue what it should give
   task automatic send_face(input face_type f, input bit typed, input cull_result_type want);
      logic [8*CB-1:0] word;
      int gap;
      if (snd_idling && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      for (int i = 0; i < NUM_CORNERS; i++) begin
         word[2*i*CB +: CB]     = f.x[i];
         word[(2*i+1)*CB +: CB] = f.y[i];
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= f.is_tri;
      do @(posedge clock); while (!req_tready);
      expected_culls.push_back(typed ? want : predict_cull(f));
   endtask

   // stop offering and let every pending result drain
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_culls.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input int value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_BITS'(value);
      case (idx)
         CSR_SCREEN_WIDTH:   cur_width  = SCREEN_BITS'(value);
         CSR_SCREEN_HEIGHT:  cur_height = SCREEN_BITS'(value);
         CSR_MIN_TWICE_AREA: cur_thr    = AREA_THR_BITS'(value);
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic cmp_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int gap_left;
      int hold_left;
      int hold_served;
      gap_left = 0;
      hold_left = 0;
      hold_served = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (!rsp_idling) gap_left = 0;
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (gap_left > 0) begin
            rsp_tready <= 1'b0;
            gap_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_idling && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 15);
         end
      end
   end

   // compare each result word with the oldest pending face
   always @(posedge clock) begin
      cull_result_type want;
      cull_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status     = rsp_tdata[1:0];
         got.top_corner = rsp_tdata[3:2];
         got.min_x      = rsp_tdata[4 +: CB];
         got.max_x      = rsp_tdata[4+CB +: CB];
         got.min_y      = rsp_tdata[4+2*CB +: CB];
         got.max_y      = rsp_tdata[4+3*CB +: CB];
         if (expected_culls.size() == 0) begin
            $error("result word with no face pending");
            fail_count++;
         end else begin
            want = expected_culls.pop_front();
            cmp_field("status", want.status, got.status);
            cmp_field("top_corner", want.top_corner, got.top_corner);
            cmp_field("min_x", want.min_x, got.min_x);
            cmp_field("max_x", want.max_x, got.max_x);
            cmp_field("min_y", want.min_y, got.min_y);
            cmp_field("max_y", want.max_y, got.max_y);
         end
      end
   end

   // stimulus
   initial begin
      stim_row_type row;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // square, both windings, corner 0 wins the y tie
      add_row(10, 10, 50, 10, 50, 50, 10, 50, 0, 24, 1, STATUS_VISIBLE, 0, 10, 50, 10, 50);
      add_row(10, 10, 10, 50, 50, 50, 50, 10, 0, 24, 1, STATUS_VISIBLE, 0, 10, 50, 10, 50);
      // off-screen in x on either side, and just on-screen at both edges
      add_row(-100, 10, -50, 10, -50, 50, -100, 50, 0, 24, 1,
              STATUS_OFF_X, 0, -100, -50, 10, 50);
      add_row(240, 10, 280, 10, 280, 50, 240, 50, 0, 24, 1, STATUS_OFF_X, 0, 240, 280, 10, 50);
      add_row(239, 10, 300, 10, 300, 50, 239, 50, 0, 24, 1, STATUS_VISIBLE, 0, 239, 300, 10, 50);
      add_row(-40, 10, 0, 10, 0, 50, -40, 50, 0, 24, 1, STATUS_VISIBLE, 0, -40, 0, 10, 50);
      // off-screen in y, below and above
      add_row(10, 160, 50, 160, 50, 200, 10, 200, 0, 24, 1,
              STATUS_OFF_Y, 0, 10, 50, 160, 200);
      add_row(10, -41, 50, -41, 50, -1, 10, -1, 0, 24, 1, STATUS_OFF_Y, 0, 10, 50, -41, -1);
      // x test beats stability, stability beats y test
      add_row(-100, 5, -100, 5, -100, 5, -100, 5, 0, 24, 1,
              STATUS_OFF_X, 0, -100, -100, 5, 5);
      add_row(10, 500, 10, 500, 10, 500, 10, 500, 0, 24, 1,
              STATUS_UNSTABLE, 0, 10, 10, 500, 500);
      // triangle area on, under and negative at the threshold
      add_row(0, 0, 6, 0, 0, 4, 0, 0, 1, 24, 1, STATUS_VISIBLE, 0, 0, 6, 0, 4);
      add_row(0, 0, 23, 0, 0, 1, 0, 0, 1, 24, 1, STATUS_UNSTABLE, 0, 0, 23, 0, 1);
      add_row(0, 0, 0, 4, 6, 0, 0, 0, 1, 24, 1, STATUS_VISIBLE, 0, 0, 6, 0, 4);
      // triangle whose spare corner sets the box and the top corner
      add_row(10, 10, 50, 10, 10, 50, -5000, -5000, 1, 24, 1,
              STATUS_VISIBLE, 3, -5000, 50, -5000, 50);
      // coordinate extremes
      add_row(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 0, 24, 1,
              STATUS_OFF_X, 0, C_MIN, C_MIN, C_MIN, C_MIN);
      add_row(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1, 24, 1,
              STATUS_OFF_X, 0, C_MAX, C_MAX, C_MAX, C_MAX);
      add_row(C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, 0, 24, 1,
              STATUS_VISIBLE, 0, C_MIN, C_MAX, C_MIN, C_MAX);
      add_row(C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, 1, 24);
      // quad too small to be stable
      add_row(10, 10, 14, 10, 14, 14, 10, 14, 0, 24, 1, STATUS_UNSTABLE, 0, 10, 14, 10, 14);
      // dart, bow-tie, three corners in a row, later top corner
      add_row(0, 0, 100, 0, 20, 20, 0, 100, 0, 24);
      add_row(10, 10, 50, 50, 50, 10, 10, 50, 0, 24);
      add_row(10, 10, 30, 10, 50, 10, 30, 50, 0, 24);
      add_row(0, 20, 40, 5, 60, 5, 20, 30, 0, 24);
      // zero-area triangle, then with a zero threshold: triangle passes, quad does not
      add_row(0, 0, 10, 10, 20, 20, 5, 0, 1, 24, 1, STATUS_UNSTABLE, 0, 0, 20, 0, 20);
      add_row(0, 0, 10, 10, 20, 20, 5, 0, 1, 0, 1, STATUS_VISIBLE, 0, 0, 20, 0, 20);
      add_row(0, 0, 10, 10, 20, 20, 5, 0, 0, 0, 1, STATUS_UNSTABLE, 0, 0, 20, 0, 20);

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.thr != cur_thr) begin
            wait_idle();
            write_reg(CSR_MIN_TWICE_AREA, row.thr);
         end
         send_face(row.face, row.known, row.want);
      end
      wait_idle();

      // random faces, one register setting per phase
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_reg(CSR_SCREEN_WIDTH, PH_W[ph]);
         write_reg(CSR_SCREEN_HEIGHT, PH_H[ph]);
         write_reg(CSR_MIN_TWICE_AREA, PH_THR[ph]);
         if (ph == HOLD_PHASE) hold_requests++;
         for (int n = 0; n < PH_ITEMS[ph]; n++) begin
            if (n % 64 == 0) begin
               snd_idling = 1'($urandom_range(0, 1));
               rsp_idling = 1'($urandom_range(0, 1));
            end
            // keep offering through the long hold so the pipe backs up
            if (ph == HOLD_PHASE && n < 120) snd_idling = 1'b0;
            if (ph == NUM_PHASES - 1) begin
               snd_idling = 1'b0;
               rsp_idling = 1'b0;
            end
            send_face(random_face(), 1'b0, '0);
         end
         wait_idle();
      end

      if (fail_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
